// ===== rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

    // Widths of the channel fields, fixed by the port definition.
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned CAP_W   = 4;

    // Defaults for the top-level parameters.
    localparam int unsigned DEF_MAX_ENTRIES = 8;
    localparam int unsigned DEF_KEY_BITS    = 32;
    localparam int unsigned DEF_VALUE_BITS  = 32;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd8;

    // Operation codes carried on the request channel.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Which cell an update targets.
    typedef enum logic [1:0] {
        SEL_HIT  = 2'd0,
        SEL_LRU  = 2'd1,
        SEL_FREE = 2'd2
    } lkv_sel_t;

    // Update command broadcast from the top level to every cell.
    typedef struct packed {
        logic     update;
        logic     write_kv;
        logic     age_all;
        lkv_sel_t sel;
    } lkv_cmd_t;

endpackage

// ===== rtl/lkv_channels.sv =====
// Handshake interfaces for the request, response and configuration channels.
interface lkv_req_if;
    import lkv_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] write_value;

    modport source (output valid, output operation, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input operation, input lookup_key, input write_value,
                    output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;
    logic [FIELD_W-1:0] evicted_value;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, output evicted_value, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, input evicted_value, output ready);
endinterface

interface lkv_cfg_if;
    import lkv_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

// ===== rtl/lkv_cell.sv =====
// One cache cell: holds an entry and passes lookup results to its neighbor.
module lkv_cell #(
    parameter int unsigned KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
    parameter int unsigned VALUE_BITS = lkv_pkg::DEF_VALUE_BITS,
    parameter int unsigned RANK_W     = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkv_pkg::lkv_cmd_t     cmd,
    input  logic [KEY_BITS-1:0]   lookup_key,
    input  logic [VALUE_BITS-1:0] write_value,
    input  logic [RANK_W-1:0]     old_rank,
    input  logic [RANK_W-1:0]     lru_rank,
    input  logic                  found_in,
    input  logic                  free_in,
    input  logic [VALUE_BITS-1:0] hit_value_in,
    input  logic [RANK_W-1:0]     hit_rank_in,
    input  logic [KEY_BITS-1:0]   lru_key_in,
    input  logic [VALUE_BITS-1:0] lru_value_in,
    output logic                  found_out,
    output logic                  free_out,
    output logic [VALUE_BITS-1:0] hit_value_out,
    output logic [RANK_W-1:0]     hit_rank_out,
    output logic [KEY_BITS-1:0]   lru_key_out,
    output logic [VALUE_BITS-1:0] lru_value_out
);
    import lkv_pkg::*;

    logic                  valid_reg, valid_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    logic hit_here;
    logic lru_here;
    logic free_here;
    logic target;

    // The first matching cell and the first free cell win; the chain masks the rest.
    assign hit_here  = valid_reg && (key_reg == lookup_key) && !found_in;
    assign lru_here  = valid_reg && (rank_reg == lru_rank);
    assign free_here = !valid_reg && !free_in;

    assign found_out     = found_in || hit_here;
    assign free_out      = free_in || !valid_reg;
    assign hit_value_out = hit_value_in | (hit_here ? value_reg : '0);
    assign hit_rank_out  = hit_rank_in | (hit_here ? rank_reg : '0);
    assign lru_key_out   = lru_key_in | (lru_here ? key_reg : '0);
    assign lru_value_out = lru_value_in | (lru_here ? value_reg : '0);

    always_comb
    begin
        case (cmd.sel)
            SEL_HIT:  target = hit_here;
            SEL_LRU:  target = lru_here;
            SEL_FREE: target = free_here;
            default:  target = 1'b0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.update)
        begin
            if (target)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                if (cmd.write_kv)
                begin
                    key_next   = lookup_key;
                    value_next = write_value;
                end
            end
            else if (valid_reg && (cmd.age_all || (rank_reg < old_rank)))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative key/value cache with LRU replacement.
//
//  Channel   Dir  Handshake      Payload
//  --------  ---  -------------  -----------------------------------------------
//  request   in   valid/ready    operation, lookup_key, write_value
//  response  out  valid/ready    hit, read_value, evicted, evicted_key, evicted_value
//  cfg       in   valid/ready    wdata (capacity, 4 bits)
//
//  Each request beat is resolved in the cycle it is accepted: the cell row
//  compares the key in every cell and updates the ranks at that clock edge,
//  and the result lands in the response register. One beat per cycle is
//  sustained while the response side keeps taking beats.
//  Reset empties every cell and sets the capacity to eight; no clearing pass.
//  While a response beat is stalled, request.ready stays low, so the block
//  holds at most one beat.
module lru_key_value_cache #(
    parameter int unsigned MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES,
    parameter int unsigned KEY_BITS    = lkv_pkg::DEF_KEY_BITS,
    parameter int unsigned VALUE_BITS  = lkv_pkg::DEF_VALUE_BITS
) (
    input logic       clk,
    input logic       rst_n,
    lkv_req_if.sink   request,
    lkv_rsp_if.source response,
    lkv_cfg_if.sink   cfg
);
    import lkv_pkg::*;

    // Rank needs to index every entry; the fill count must also hold MAX_ENTRIES.
    localparam int unsigned RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Config register: the user writes only while the block is idle; not enforced.
    logic [CAP_W-1:0] capacity_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg.valid)
        begin
            capacity_reg <= cfg.wdata;
        end
    end

    // Effective capacity: zero acts as one and values past the cell count saturate.
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CNT_W-1:0] occupancy_reg, occupancy_next;
    logic             full;

    assign cap_ext = CMP_W'(capacity_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full = CMP_W'(occupancy_reg) >= eff_cap;

    // Handshake: a response register separates the two sides.
    logic accept;
    logic rsp_valid_reg;

    assign request.ready = !rsp_valid_reg || response.ready;
    assign accept        = request.valid && request.ready;

    // Request payload brought to the storage widths.
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic                  is_put;

    assign req_key   = KEY_BITS'(request.lookup_key);
    assign req_value = VALUE_BITS'(request.write_value);
    assign is_put    = (request.operation == OP_PUT);

    // Chain wires between neighboring cells; index 0 feeds the first cell.
    logic                  found_c     [MAX_ENTRIES+1];
    logic                  free_c      [MAX_ENTRIES+1];
    logic [VALUE_BITS-1:0] hit_value_c [MAX_ENTRIES+1];
    logic [RANK_W-1:0]     hit_rank_c  [MAX_ENTRIES+1];
    logic [KEY_BITS-1:0]   lru_key_c   [MAX_ENTRIES+1];
    logic [VALUE_BITS-1:0] lru_value_c [MAX_ENTRIES+1];

    assign found_c[0]     = 1'b0;
    assign free_c[0]      = 1'b0;
    assign hit_value_c[0] = '0;
    assign hit_rank_c[0]  = '0;
    assign lru_key_c[0]   = '0;
    assign lru_value_c[0] = '0;

    // The least recent entry holds rank occupancy-1, since valid ranks are dense.
    logic [RANK_W-1:0] lru_rank;
    logic [RANK_W-1:0] old_rank;
    lkv_cmd_t          cmd;
    logic              any_hit;

    assign lru_rank = RANK_W'(occupancy_reg - 1'b1);
    assign any_hit  = found_c[MAX_ENTRIES];

    // Decide the update from the chain results and broadcast it to every cell.
    always_comb
    begin
        cmd.update     = 1'b0;
        cmd.write_kv   = 1'b0;
        cmd.age_all    = 1'b0;
        cmd.sel        = SEL_HIT;
        old_rank       = hit_rank_c[MAX_ENTRIES];
        occupancy_next = occupancy_reg;
        if (any_hit)
        begin
            // Hit: move the entry to the front, a put also rewrites its value.
            cmd.update   = accept;
            cmd.write_kv = is_put;
        end
        else if (is_put)
        begin
            cmd.update   = accept;
            cmd.write_kv = 1'b1;
            if (full)
            begin
                // Miss on a full store: reuse the slot of the least recent entry.
                cmd.sel  = SEL_LRU;
                old_rank = lru_rank;
            end
            else
            begin
                // Miss with room left: fill the lowest free cell, all others age.
                cmd.sel     = SEL_FREE;
                cmd.age_all = 1'b1;
                if (accept)
                begin
                    occupancy_next = occupancy_reg + 1'b1;
                end
            end
        end
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .RANK_W     (RANK_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .lookup_key    (req_key),
            .write_value   (req_value),
            .old_rank      (old_rank),
            .lru_rank      (lru_rank),
            .found_in      (found_c[i]),
            .free_in       (free_c[i]),
            .hit_value_in  (hit_value_c[i]),
            .hit_rank_in   (hit_rank_c[i]),
            .lru_key_in    (lru_key_c[i]),
            .lru_value_in  (lru_value_c[i]),
            .found_out     (found_c[i+1]),
            .free_out      (free_c[i+1]),
            .hit_value_out (hit_value_c[i+1]),
            .hit_rank_out  (hit_rank_c[i+1]),
            .lru_key_out   (lru_key_c[i+1]),
            .lru_value_out (lru_value_c[i+1])
        );
    end

    // The fill count never exceeds the number of cells, so it is a plain counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
        end
        else
        begin
            occupancy_reg <= occupancy_next;
        end
    end

    // Response register. Fields that do not apply to this beat read as zero.
    logic               hit_reg;
    logic [FIELD_W-1:0] read_value_reg;
    logic               evicted_reg;
    logic [FIELD_W-1:0] evicted_key_reg;
    logic [FIELD_W-1:0] evicted_value_reg;
    logic               evict_now;

    assign evict_now = is_put && !any_hit && full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg           <= any_hit;
            read_value_reg    <= (any_hit && !is_put)
                                 ? FIELD_W'(hit_value_c[MAX_ENTRIES]) : '0;
            evicted_reg       <= evict_now;
            evicted_key_reg   <= evict_now ? FIELD_W'(lru_key_c[MAX_ENTRIES]) : '0;
            evicted_value_reg <= evict_now ? FIELD_W'(lru_value_c[MAX_ENTRIES]) : '0;
        end
    end

    assign response.valid         = rsp_valid_reg;
    assign response.hit           = hit_reg;
    assign response.read_value    = read_value_reg;
    assign response.evicted       = evicted_reg;
    assign response.evicted_key   = evicted_key_reg;
    assign response.evicted_value = evicted_value_reg;

endmodule
